>>> design/bedg_pkg.sv
// ----------------------------------------------------------------------------
// bedg_pkg: shared types and constants
// Widths, register indexes and inter-module structs for the binaural EC
// difference grid.
// ----------------------------------------------------------------------------
package bedg_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int DIFF_W     = PROD_W + 1;
  localparam int MAG_SHIFT  = 12;
  localparam int MAG_W      = DIFF_W - MAG_SHIFT;
  localparam int SUM_W      = 28;
  localparam int MEAN_W     = 20;
  localparam int IDX_W      = 3;
  localparam int COUNT_W    = 3;
  localparam int BL_W       = 4;

  // Clamped counts and grid dimensions
  localparam int CNT_W      = 5;
  localparam int ROW_CNT_W  = 4;
  localparam int COL_CNT_W  = 5;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_GAIN_REGS = 4;

  // Parameter defaults
  localparam int DEF_MAX_DELAYS     = 4;
  localparam int DEF_MAX_GAINS      = 4;
  localparam int DEF_MAX_BLOCK_LOG2 = 8;

  // Register reset values
  localparam logic [COUNT_W-1:0] DELAY_COUNT_RST = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] GAIN_COUNT_RST  = COUNT_W'(1);
  localparam logic [BL_W-1:0]    BLOCK_LOG2_RST  = BL_W'(6);
  localparam logic signed [GAIN_W-1:0] GAIN_RST  = 16'sd4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [SUM_W-1:0]           sum_t;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DELAY_COUNT = 3'd0,
    REG_GAIN_COUNT  = 3'd1,
    REG_GAIN_ZERO   = 3'd2,
    REG_GAIN_ONE    = 3'd3,
    REG_GAIN_TWO    = 3'd4,
    REG_GAIN_THREE  = 3'd5,
    REG_BLOCK_LOG2  = 3'd6
  } cfg_reg_t;

  // Effective configuration seen by the accumulator grid
  typedef struct packed {
    logic [CNT_W-1:0]     nd;
    logic [CNT_W-1:0]     ng;
    logic [ROW_CNT_W-1:0] rows;
    logic [COL_CNT_W-1:0] cols;
    logic [BL_W-1:0]      bl;
  } grid_cfg_t;

  // Snapshot load request toward the drain stage
  typedef struct packed {
    logic                 load;
    logic [ROW_CNT_W-1:0] rows;
    logic [COL_CNT_W-1:0] cols;
    logic [BL_W-1:0]      bl;
  } snap_load_t;

endpackage

>>> design/bedg_in_if.sv
// ----------------------------------------------------------------------------
// bedg_in_if: sample pair channel
// Valid/ready channel carrying one left/right sample pair per word.
// ----------------------------------------------------------------------------
interface bedg_in_if;
  import bedg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);

endinterface

>>> design/bedg_out_if.sv
// ----------------------------------------------------------------------------
// bedg_out_if: grid result channel
// Valid/ready channel carrying one grid cell mean per word.
// ----------------------------------------------------------------------------
interface bedg_out_if;
  import bedg_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  gain_row;
  logic [IDX_W-1:0]  delay_col;
  logic [MEAN_W-1:0] mean_abs_diff;
  logic              last;

  modport source (output valid, output gain_row, output delay_col,
                  output mean_abs_diff, output last, input ready);
  modport sink   (input valid, input gain_row, input delay_col,
                  input mean_abs_diff, input last, output ready);

endinterface

>>> design/bedg_grid.sv
// ----------------------------------------------------------------------------
// bedg_grid: sample history and cell accumulators
// Holds the delay lines and one saturating accumulator per grid cell; all
// active cells update together on each accepted sample pair.
// ----------------------------------------------------------------------------
module bedg_grid #(
  parameter int MAX_DELAYS     = bedg_pkg::DEF_MAX_DELAYS,
  parameter int MAX_GAINS      = bedg_pkg::DEF_MAX_GAINS,
  parameter int MAX_BLOCK_LOG2 = bedg_pkg::DEF_MAX_BLOCK_LOG2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  bedg_pkg::sample_t   left_sample,
  input  bedg_pkg::sample_t   right_sample,
  input  bedg_pkg::grid_cfg_t cfg,
  input  bedg_pkg::gain_t     gains [bedg_pkg::NUM_GAIN_REGS],
  output logic                block_end,
  output bedg_pkg::sum_t      upd_sums [2*MAX_GAINS-1][2*MAX_DELAYS-1]
);
  import bedg_pkg::*;

  localparam int NR  = 2 * MAX_GAINS - 1;
  localparam int NC  = 2 * MAX_DELAYS - 1;
  localparam int PCW = MAX_BLOCK_LOG2 + 1;

  sample_t left_hist_r  [MAX_DELAYS];
  sample_t right_hist_r [MAX_DELAYS];
  sum_t    sum_r [NR][NC];
  logic [PCW-1:0] pair_cnt_r;

  prod_t lp [NUM_GAIN_REGS][MAX_DELAYS];
  prod_t rp [NUM_GAIN_REGS][MAX_DELAYS];

  logic [PCW:0] blk_len;

  // Shared product table: every gain against every history tap
  always_comb begin
    for (int g = 0; g < NUM_GAIN_REGS; g++) begin
      for (int k = 0; k < MAX_DELAYS; k++) begin
        lp[g][k] = gains[g] * left_hist_r[k];
        rp[g][k] = gains[g] * right_hist_r[k];
      end
    end
  end

  // Block ends on the pair that brings the count to the block length
  assign blk_len   = (PCW + 1)'(1) << cfg.bl;
  assign block_end = ({1'b0, pair_cnt_r} + (PCW + 1)'(1)) >= blk_len;

  // Per-cell difference, magnitude and saturating add
  for (genvar r = 0; r < NR; r++) begin : g_row
    localparam int GI = (r + 1) / 2;
    for (genvar c = 0; c < NC; c++) begin : g_col
      localparam int ZI = (c + 1) / 2;
      localparam int DR = (c % 2 == 1) ? ZI : ZI + 1;

      logic [CNT_W-1:0] lidx;
      logic [CNT_W-1:0] gri;
      prod_t            lv;
      prod_t            rv;
      logic [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0] mag;
      logic [SUM_W:0]   acc;
      logic             active;

      assign lidx = cfg.nd - CNT_W'(ZI) - CNT_W'(1);
      assign gri  = (r % 2 == 1) ? (cfg.ng - CNT_W'(GI))
                                 : (cfg.ng - CNT_W'(GI) - CNT_W'(1));
      assign active = (ROW_CNT_W'(r) < cfg.rows) && (COL_CNT_W'(c) < cfg.cols);

      // left term: fixed gain per row, delay tap follows the delay count
      if (GI < NUM_GAIN_REGS) begin : g_gl
        always_comb begin
          lv = '0;
          for (int k = 0; k < MAX_DELAYS; k++) begin
            if (lidx == CNT_W'(k)) lv = lp[GI][k];
          end
        end
      end else begin : g_gl_zero
        assign lv = '0;
      end

      // right term: fixed delay tap per column, gain follows the gain count
      always_comb begin
        rv = '0;
        for (int g = 0; g < NUM_GAIN_REGS; g++) begin
          if (gri == CNT_W'(g)) rv = rp[g][DR-1];
        end
      end

      assign diff = {lv[PROD_W-1], lv} - {rv[PROD_W-1], rv};
      assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      assign acc  = {1'b0, sum_r[r][c]}
                  + (SUM_W + 1)'(mag[DIFF_W-1:MAG_SHIFT]);

      always_comb begin
        if (!active) begin
          upd_sums[r][c] = sum_r[r][c];
        end else if (acc[SUM_W]) begin
          upd_sums[r][c] = '1;
        end else begin
          upd_sums[r][c] = acc[SUM_W-1:0];
        end
      end
    end
  end

  // State: history, accumulators, pair count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r <= '0;
      for (int k = 0; k < MAX_DELAYS; k++) begin
        left_hist_r[k]  <= '0;
        right_hist_r[k] <= '0;
      end
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NC; c++) sum_r[r][c] <= '0;
      end
    end else if (accept) begin
      left_hist_r[0]  <= left_sample;
      right_hist_r[0] <= right_sample;
      for (int k = 1; k < MAX_DELAYS; k++) begin
        left_hist_r[k]  <= left_hist_r[k-1];
        right_hist_r[k] <= right_hist_r[k-1];
      end
      pair_cnt_r <= block_end ? '0 : pair_cnt_r + PCW'(1);
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NC; c++) begin
          sum_r[r][c] <= block_end ? '0 : upd_sums[r][c];
        end
      end
    end
  end

endmodule

>>> design/bedg_drain.sv
// ----------------------------------------------------------------------------
// bedg_drain: block snapshot and result output
// Captures the finished grid at a block end and streams it out in row-major
// order, one cell mean per word, through an output register.
// ----------------------------------------------------------------------------
module bedg_drain #(
  parameter int MAX_DELAYS = bedg_pkg::DEF_MAX_DELAYS,
  parameter int MAX_GAINS  = bedg_pkg::DEF_MAX_GAINS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bedg_pkg::snap_load_t ld,
  input  bedg_pkg::sum_t       sums [2*MAX_GAINS-1][2*MAX_DELAYS-1],
  output logic                 busy,
  output logic                 pop_last,
  bedg_out_if.source           out_ch
);
  import bedg_pkg::*;

  localparam int NR = 2 * MAX_GAINS - 1;
  localparam int NC = 2 * MAX_DELAYS - 1;

  sum_t snap_r [NR][NC];
  logic                 busy_r;
  logic [ROW_CNT_W-1:0] rows_r;
  logic [COL_CNT_W-1:0] cols_r;
  logic [BL_W-1:0]      bl_r;
  logic [ROW_CNT_W-1:0] row_r;
  logic [COL_CNT_W-1:0] col_r;

  logic              out_valid_r;
  logic [IDX_W-1:0]  gain_row_r;
  logic [IDX_W-1:0]  delay_col_r;
  logic [MEAN_W-1:0] mean_r;
  logic              last_r;

  logic       pop;
  logic       row_done;
  logic       grid_done;
  sum_t       head_shift;
  logic [MEAN_W-1:0] head_mean;

  // Move the head cell into the output register when it is free
  assign pop       = busy_r && (!out_valid_r || out_ch.ready);
  assign row_done  = (col_r == cols_r - COL_CNT_W'(1));
  assign grid_done = row_done && (row_r == rows_r - ROW_CNT_W'(1));
  assign pop_last  = pop && grid_done;
  assign busy      = busy_r;

  // Mean of the head cell, saturated
  assign head_shift = snap_r[0][0] >> bl_r;
  assign head_mean  = (|head_shift[SUM_W-1:MEAN_W]) ? '1 : head_shift[MEAN_W-1:0];

  // Snapshot storage: rows move up after a row ends, else row 0 moves left
  always_ff @(posedge clk) begin
    if (ld.load) begin
      snap_r <= sums;
    end else if (pop) begin
      if (row_done) begin
        for (int i = 0; i < NR - 1; i++) snap_r[i] <= snap_r[i+1];
      end else begin
        for (int j = 0; j < NC - 1; j++) snap_r[0][j] <= snap_r[0][j+1];
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (pop) begin
      gain_row_r  <= row_r[IDX_W-1:0];
      delay_col_r <= col_r[IDX_W-1:0];
      mean_r      <= head_mean;
      last_r      <= grid_done;
    end
  end

  // Drain control and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      rows_r      <= '0;
      cols_r      <= '0;
      bl_r        <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (ld.load) begin
        busy_r <= 1'b1;
        rows_r <= ld.rows;
        cols_r <= ld.cols;
        bl_r   <= ld.bl;
        row_r  <= '0;
        col_r  <= '0;
      end else if (pop_last) begin
        busy_r <= 1'b0;
      end else if (pop) begin
        if (row_done) begin
          col_r <= '0;
          row_r <= row_r + ROW_CNT_W'(1);
        end else begin
          col_r <= col_r + COL_CNT_W'(1);
        end
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.gain_row      = gain_row_r;
  assign out_ch.delay_col     = delay_col_r;
  assign out_ch.mean_abs_diff = mean_r;
  assign out_ch.last          = last_r;

endmodule

>>> design/binaural_ei_difference_grid.sv
// ----------------------------------------------------------------------------
// binaural_ei_difference_grid: equalization-cancellation difference grid
// Accumulates |gl*L(t-dl) - gr*R(t-dr)| over a gain/lag grid and reports
// per-cell block means.
// ----------------------------------------------------------------------------
// One sample pair is taken per clock: every active grid cell updates in
// parallel in the cycle the pair is accepted. When a pair completes a block
// of 2^block_log2 pairs, the finished grid is copied into a snapshot and
// streamed out as (2G-1)*(2D-1) words in row-major order, one per cycle while
// the sink is ready, through the output register; last marks the final cell.
// Accumulation of the next block goes on during the drain. Only a pair that
// would end a further block waits, until the previous snapshot has handed its
// last cell to the output register, so with long blocks the rate is one pair
// per cycle and with short ones it is set by the drain length per block.
// ----------------------------------------------------------------------------
module binaural_ei_difference_grid #(
  parameter int MAX_DELAYS     = bedg_pkg::DEF_MAX_DELAYS,
  parameter int MAX_GAINS      = bedg_pkg::DEF_MAX_GAINS,
  parameter int MAX_BLOCK_LOG2 = bedg_pkg::DEF_MAX_BLOCK_LOG2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bedg_in_if.sink                          in_ch,
  bedg_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bedg_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [bedg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bedg_pkg::*;

  localparam int NR = 2 * MAX_GAINS - 1;
  localparam int NC = 2 * MAX_DELAYS - 1;

  logic [COUNT_W-1:0] delay_count_r;
  logic [COUNT_W-1:0] gain_count_r;
  gain_t              gain_r [NUM_GAIN_REGS];
  logic [BL_W-1:0]    block_log2_r;

  grid_cfg_t  gcfg;
  snap_load_t ld;
  logic       block_end;
  logic       accept;
  logic       drain_busy;
  logic       drain_last;
  sum_t       upd_sums [NR][NC];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_count_r <= DELAY_COUNT_RST;
      gain_count_r  <= GAIN_COUNT_RST;
      block_log2_r  <= BLOCK_LOG2_RST;
      for (int g = 0; g < NUM_GAIN_REGS; g++) gain_r[g] <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_COUNT: delay_count_r <= cfg_data[COUNT_W-1:0];
        REG_GAIN_COUNT:  gain_count_r  <= cfg_data[COUNT_W-1:0];
        REG_GAIN_ZERO:   gain_r[0]     <= cfg_data;
        REG_GAIN_ONE:    gain_r[1]     <= cfg_data;
        REG_GAIN_TWO:    gain_r[2]     <= cfg_data;
        REG_GAIN_THREE:  gain_r[3]     <= cfg_data;
        REG_BLOCK_LOG2:  block_log2_r  <= cfg_data[BL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero reads as one, large values clamp to the maximum
  always_comb begin
    if (delay_count_r == '0) begin
      gcfg.nd = CNT_W'(1);
    end else if (CNT_W'(delay_count_r) > CNT_W'(MAX_DELAYS)) begin
      gcfg.nd = CNT_W'(MAX_DELAYS);
    end else begin
      gcfg.nd = CNT_W'(delay_count_r);
    end

    if (gain_count_r == '0) begin
      gcfg.ng = CNT_W'(1);
    end else if (CNT_W'(gain_count_r) > CNT_W'(MAX_GAINS)) begin
      gcfg.ng = CNT_W'(MAX_GAINS);
    end else begin
      gcfg.ng = CNT_W'(gain_count_r);
    end

    if (block_log2_r > BL_W'(MAX_BLOCK_LOG2)) begin
      gcfg.bl = BL_W'(MAX_BLOCK_LOG2);
    end else begin
      gcfg.bl = block_log2_r;
    end

    gcfg.rows = ROW_CNT_W'({gcfg.ng, 1'b0} - (CNT_W + 1)'(1));
    gcfg.cols = COL_CNT_W'({gcfg.nd, 1'b0} - (CNT_W + 1)'(1));
  end

  // Hold a block-ending pair only while the previous grid is still draining
  assign in_ch.ready = !drain_busy || !block_end || drain_last;
  assign accept      = in_ch.valid && in_ch.ready;

  assign ld.load = accept && block_end;
  assign ld.rows = gcfg.rows;
  assign ld.cols = gcfg.cols;
  assign ld.bl   = gcfg.bl;

  bedg_grid #(
    .MAX_DELAYS     (MAX_DELAYS),
    .MAX_GAINS      (MAX_GAINS),
    .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2)
  ) u_grid (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .cfg          (gcfg),
    .gains        (gain_r),
    .block_end    (block_end),
    .upd_sums     (upd_sums)
  );

  bedg_drain #(
    .MAX_DELAYS (MAX_DELAYS),
    .MAX_GAINS  (MAX_GAINS)
  ) u_drain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .sums     (upd_sums),
    .busy     (drain_busy),
    .pop_last (drain_last),
    .out_ch   (out_ch)
  );

endmodule
